@@ rtl/core/isl_pkg.sv @@
// ----------------------------------------------------------------------------
// isl_pkg: shared definitions for the indexed shift list
// Operation, status and cell action codes, plus default sizes.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int ISL_CAPACITY  = 16;
  localparam int ISL_WORD_BITS = 32;

  localparam int OP_W     = 4;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int POS2_W   = 4;
  localparam int NLEN_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CLEN_W   = 5;

  localparam logic [OP_W-1:0] OP_APPEND       = 4'd0;
  localparam logic [OP_W-1:0] OP_PREPEND      = 4'd1;
  localparam logic [OP_W-1:0] OP_INSERT_AT    = 4'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_LAST  = 4'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_FIRST = 4'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_AT    = 4'd5;
  localparam logic [OP_W-1:0] OP_READ_AT      = 4'd6;
  localparam logic [OP_W-1:0] OP_SWAP         = 4'd7;
  localparam logic [OP_W-1:0] OP_REPLACE_ALL  = 4'd8;
  localparam logic [OP_W-1:0] OP_CLEAR        = 4'd9;
  localparam logic [OP_W-1:0] OP_RESIZE       = 4'd10;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam int ACT_W = 3;
  typedef logic [ACT_W-1:0] act_t;

  localparam act_t ACT_NONE    = 3'd0;
  localparam act_t ACT_INSERT  = 3'd1;
  localparam act_t ACT_REMOVE  = 3'd2;
  localparam act_t ACT_SWAP    = 3'd3;
  localparam act_t ACT_REPLACE = 3'd4;
  localparam act_t ACT_FILL    = 3'd5;

endpackage

@@ rtl/core/isl_cell.sv @@
// ----------------------------------------------------------------------------
// isl_cell: one list entry
// Holds one word; shifts from either neighbour, loads, swaps, replaces on
// match or zero-fills as the broadcast action and indices direct.
// ----------------------------------------------------------------------------
module isl_cell
  import isl_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int WORD_BITS = ISL_WORD_BITS,
  parameter int CMP_W     = 5
) (
  input  logic                 clk,
  input  act_t                 act,
  input  logic [CMP_W-1:0]     pos,
  input  logic [CMP_W-1:0]     pos2,
  input  logic [CMP_W-1:0]     len,
  input  logic [CMP_W-1:0]     nlen,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [WORD_BITS-1:0] match,
  input  logic [WORD_BITS-1:0] swap_a,
  input  logic [WORD_BITS-1:0] swap_b,
  input  logic [WORD_BITS-1:0] left_q,
  input  logic [WORD_BITS-1:0] right_q,
  output logic [WORD_BITS-1:0] q
);

  localparam logic [CMP_W-1:0] MY_IDX  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] MY_NEXT = CMP_W'(IDX + 1);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (act)
      ACT_INSERT: begin
        if (MY_IDX == pos) begin
          word_nxt = wdata;
        end else if (MY_IDX > pos && MY_IDX <= len) begin
          word_nxt = left_q;
        end
      end
      ACT_REMOVE: begin
        if (MY_IDX >= pos && MY_NEXT < len) begin
          word_nxt = right_q;
        end
      end
      ACT_SWAP: begin
        if (MY_IDX == pos) begin
          word_nxt = swap_a;
        end else if (MY_IDX == pos2) begin
          word_nxt = swap_b;
        end
      end
      ACT_REPLACE: begin
        if (MY_IDX < len && word_r == match) begin
          word_nxt = wdata;
        end
      end
      ACT_FILL: begin
        if (MY_IDX >= len && MY_IDX < nlen) begin
          word_nxt = '0;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

@@ rtl/core/indexed_shift_list_core.sv @@
// ----------------------------------------------------------------------------
// indexed_shift_list_core: bounded ordered word list in a row of cells
// Latency: the result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle unless the input is stalled; each request updates all cells at once.
// Input stalls only while a result is held by a stalled output.
// Reset clears the length and the output valid; entry contents are not reset.
// ----------------------------------------------------------------------------
module indexed_shift_list_core
  import isl_pkg::*;
#(
  parameter int CAPACITY  = ISL_CAPACITY,
  parameter int WORD_BITS = ISL_WORD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [DATA_W-1:0]   in_value,
  input  logic [DATA_W-1:0]   in_match_value,
  input  logic [POS_W-1:0]    in_position,
  input  logic [POS2_W-1:0]   in_other_position,
  input  logic [NLEN_W-1:0]   in_new_length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [STATUS_W-1:0] out_status,
  output logic [CLEN_W-1:0]   out_current_length
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam logic [CMP_W-1:0] CAP = CMP_W'(CAPACITY);

  logic [WORD_BITS-1:0] q [CAPACITY];

  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   len_nxt;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_read_data_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CLEN_W-1:0]  out_current_length_r;

  logic               accept;
  logic [CMP_W-1:0]   len_x;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   pos2_x;
  logic [CMP_W-1:0]   nlen_x;
  logic [CMP_W-1:0]   cpos;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] match;
  logic [WORD_BITS-1:0] word_at_pos;
  logic [WORD_BITS-1:0] word_at_pos2;
  act_t               act;
  logic [DATA_W-1:0]  rd;
  logic [STATUS_W-1:0] st;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;

  assign len_x  = CMP_W'(len_r);
  assign pos_x  = CMP_W'(in_position);
  assign pos2_x = CMP_W'(in_other_position);
  assign nlen_x = CMP_W'(in_new_length);
  assign wdata  = WORD_BITS'(in_value);
  assign match  = WORD_BITS'(in_match_value);

  assign word_at_pos  = q[pos_x[IDX_W-1:0]];
  assign word_at_pos2 = q[pos2_x[IDX_W-1:0]];

  always_comb begin
    act     = ACT_NONE;
    rd      = '0;
    st      = ST_OK;
    len_nxt = len_r;
    cpos    = pos_x;
    unique case (in_operation)
      OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
        if (in_operation == OP_APPEND) begin
          cpos = len_x;
        end else if (in_operation == OP_PREPEND) begin
          cpos = '0;
        end
        if (cpos > len_x) begin
          st = ST_BAD;
        end else if (len_x >= CAP) begin
          st = ST_FULL;
        end else begin
          act     = ACT_INSERT;
          len_nxt = len_r + LEN_W'(1);
        end
      end
      OP_REMOVE_LAST, OP_REMOVE_FIRST, OP_REMOVE_AT: begin
        if (in_operation == OP_REMOVE_LAST) begin
          cpos = len_x - CMP_W'(1);
        end else if (in_operation == OP_REMOVE_FIRST) begin
          cpos = '0;
        end
        if (len_r == '0 || cpos >= len_x) begin
          st = ST_BAD;
        end else begin
          act     = ACT_REMOVE;
          len_nxt = len_r - LEN_W'(1);
        end
      end
      OP_READ_AT: begin
        if (pos_x >= len_x) begin
          st = ST_BAD;
        end else begin
          rd = DATA_W'(word_at_pos);
        end
      end
      OP_SWAP: begin
        if (pos_x >= len_x || pos2_x >= len_x) begin
          st = ST_BAD;
        end else begin
          act = ACT_SWAP;
        end
      end
      OP_REPLACE_ALL: begin
        act = ACT_REPLACE;
      end
      OP_CLEAR: begin
        len_nxt = '0;
      end
      OP_RESIZE: begin
        if (nlen_x > CAP) begin
          st = ST_FULL;
        end else begin
          act     = ACT_FILL;
          len_nxt = LEN_W'(nlen_x);
        end
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
    if (!accept) begin
      act = ACT_NONE;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_q;
    logic [WORD_BITS-1:0] right_q;

    if (g == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = q[g+1];
    end

    isl_cell #(
      .IDX       (g),
      .WORD_BITS (WORD_BITS),
      .CMP_W     (CMP_W)
    ) u_cell (
      .clk     (clk),
      .act     (act),
      .pos     (cpos),
      .pos2    (pos2_x),
      .len     (len_x),
      .nlen    (nlen_x),
      .wdata   (wdata),
      .match   (match),
      .swap_a  (word_at_pos2),
      .swap_b  (word_at_pos),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_data_r      <= rd;
      out_status_r         <= st;
      out_current_length_r <= CLEN_W'(len_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_status         = out_status_r;
  assign out_current_length = out_current_length_r;

endmodule
